// File: hw/rtl/apbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbm_pkg
// Shared constants and codes for the ASK/PSK bit modulator.
// ----------------------------------------------------------------------------
package apbm_pkg;

   localparam int QUEUE_DEPTH_DEF     = 32;
   localparam int FRAME_WIDTH_DEF     = 32;
   localparam int MAX_SYMBOL_BITS_DEF = 4;

   localparam int TICK_W      = 12;
   localparam int WORD_W      = 32;
   localparam int REQ_USER_W  = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;
   localparam int PENDING_W   = 6;
   localparam int BPS_W       = 3;
   localparam int PPB_W       = 8;
   localparam int FLEN_W      = 6;
   localparam int MODE_W      = 2;

   localparam logic [REQ_USER_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [REQ_USER_W-1:0] REQ_START  = 2'd1;
   localparam logic [REQ_USER_W-1:0] REQ_TICK   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_ASK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DPSK = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BPS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PPB  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FLEN = 2'd3;

endpackage

// File: hw/rtl/apbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ask_psk_bit_modulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ask_psk_bit_modulator_top
// Queued-frame ASK / PSK / DPSK square-wave line modulator.
//
// Usage:
//  - req channel: tuser carries the request kind (append, start, tick),
//    tdata the frame word for an append. Every request transfer yields
//    exactly one rsp transfer with the line level and queue status.
//  - csr port: write-only registers (mode, bits per symbol, periods per
//    bit, frame length), to be written by the user only while the block
//    is idle; the block itself does not enforce this.
//  - Append, start and ticks while done respond in the cycle after the
//    transfer. An ASK tick reads the frame RAM, then updates the bit. A
//    PSK tick inside a symbol only updates the phase; one starting a symbol
//    reads RAM once per gathered bit, then updates symbol and phase.
//  - One request is processed at a time; req_tready is low while a tick
//    is in progress or a response waits on a stalled receiver.
//  - Reset restores register defaults, empties the queue, sets done and
//    parks the line idle. Queue RAM contents are not cleared.
// ----------------------------------------------------------------------------
module ask_psk_bit_modulator_top #(
   parameter int QUEUE_DEPTH     = apbm_pkg::QUEUE_DEPTH_DEF,
   parameter int FRAME_WIDTH     = apbm_pkg::FRAME_WIDTH_DEF,
   parameter int MAX_SYMBOL_BITS = apbm_pkg::MAX_SYMBOL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // tuser: [1:0] req_type
   input  logic [apbm_pkg::REQ_USER_W-1:0]    req_tuser,
   // tdata: [31:0] frame_word
   input  logic [apbm_pkg::WORD_W-1:0]        req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: [0] load_active, [1] tx_done, [2] frame_dropped,
   //        [8:3] frames_pending, [15:9] zero
   output logic [apbm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [apbm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [apbm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import apbm_pkg::*;

   localparam int QW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int BPW   = $clog2(FRAME_WIDTH);
   localparam int SW    = MAX_SYMBOL_BITS;
   localparam int IW    = $clog2(MAX_SYMBOL_BITS + 1);
   localparam int LEN_W = ($clog2(FRAME_WIDTH + 1) > FLEN_W) ?
                          $clog2(FRAME_WIDTH + 1) : FLEN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_ASK_BIT,
      S_GATHER,
      S_PSK_BIT,
      S_SYMBOL,
      S_PHASE
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [BPS_W-1:0]  bps_ff, bps_in;
   logic [PPB_W-1:0]  ppb_ff, ppb_in;
   logic [FLEN_W-1:0] flen_ff, flen_in;

   logic [QW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [BPW-1:0]    bp_ff, bp_in;
   logic [TICK_W-1:0] tc_ff, tc_in;
   logic [SW-1:0]     sym_ff, sym_in;
   logic              idle_ff, idle_in;
   logic              finished_ff, finished_in;
   logic [SW-1:0]     bits_ff, bits_in;
   logic [IW-1:0]     gcnt_ff, gcnt_in;
   logic              dropped_ff, dropped_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                   ram_wr_en;
   logic [QW-1:0]          ram_wr_addr;
   logic [FRAME_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [FRAME_WIDTH-1:0] ram_rd_data;

   logic                req_xfer;
   logic [LEN_W-1:0]    len_raw, eff_len, eff_len_m1;
   logic [BPS_W-1:0]    eff_n;
   logic [SW:0]         tpp;
   logic [SW-1:0]       sym_mask, sym_half, phase;
   logic [TICK_W:0]     tick_inc, ask_limit, psk_limit;
   logic [CW:0]         wr_sum;
   logic                cur_bit;
   logic [BPW-1:0]      adv_bp;
   logic [QW-1:0]       adv_head;
   logic [CW-1:0]       adv_count;

   apbm_ram #(
      .WIDTH (FRAME_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PENDING_W - 3)'(0), PENDING_W'(count_ff),
                        dropped_ff, finished_ff, ~idle_ff};

   // effective frame length and symbol width
   always_comb begin
      len_raw = LEN_W'(flen_ff);
      if (len_raw == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_raw > LEN_W'(FRAME_WIDTH)) begin
         eff_len = LEN_W'(FRAME_WIDTH);
      end else begin
         eff_len = len_raw;
      end
      eff_len_m1 = eff_len - LEN_W'(1);

      if (bps_ff == '0) begin
         eff_n = BPS_W'(1);
      end else if (bps_ff > BPS_W'(MAX_SYMBOL_BITS)) begin
         eff_n = BPS_W'(MAX_SYMBOL_BITS);
      end else begin
         eff_n = bps_ff;
      end
   end

   assign tpp       = (SW + 1)'(1) << eff_n;
   assign sym_mask  = SW'(tpp - (SW + 1)'(1));
   assign sym_half  = SW'(tpp >> 1);
   assign phase     = (tc_ff[SW-1:0] + sym_ff) & sym_mask;
   assign tick_inc  = {1'b0, tc_ff} + (TICK_W + 1)'(1);
   assign ask_limit = (TICK_W + 1)'({ppb_ff, 1'b0});
   assign psk_limit = (TICK_W + 1)'(ppb_ff) << eff_n;
   assign cur_bit   = ram_rd_data[bp_ff];

   assign wr_sum      = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign ram_wr_addr = (wr_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                        QW'(wr_sum - (CW + 1)'(QUEUE_DEPTH)) : QW'(wr_sum);
   assign ram_wr_data = FRAME_WIDTH'(req_tdata);

   // next bit position / queue pointer after one bit is consumed
   always_comb begin
      adv_bp    = bp_ff - BPW'(1);
      adv_head  = head_ff;
      adv_count = count_ff;
      if (bp_ff == '0) begin
         adv_bp   = eff_len_m1[BPW-1:0];
         adv_head = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QW'(1);
         if (count_ff != '0) begin
            adv_count = count_ff - CW'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      bps_in       = bps_ff;
      ppb_in       = ppb_ff;
      flen_in      = flen_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      bp_in        = bp_ff;
      tc_in        = tc_ff;
      sym_in       = sym_ff;
      idle_in      = idle_ff;
      finished_in  = finished_ff;
      bits_in      = bits_ff;
      gcnt_in      = gcnt_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            REG_MODE: mode_in = csr_wdata[MODE_W-1:0];
            REG_BPS:  bps_in  = csr_wdata[BPS_W-1:0];
            REG_PPB:  ppb_in  = csr_wdata[PPB_W-1:0];
            REG_FLEN: flen_in = csr_wdata[FLEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               dropped_in = 1'b0;
               unique case (req_tuser)
                  REQ_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        dropped_in = 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  REQ_START: begin
                     rsp_valid_in = 1'b1;
                     bp_in        = eff_len_m1[BPW-1:0];
                     tc_in        = '0;
                     sym_in       = '0;
                     idle_in      = 1'b1;
                     finished_in  = 1'b0;
                  end
                  REQ_TICK: begin
                     if (finished_ff) begin
                        rsp_valid_in = 1'b1;
                     end else if (mode_ff != MODE_ASK && tc_ff != '0) begin
                        state_in = S_PHASE;
                     end else if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        idle_in      = 1'b0;
                        finished_in  = 1'b1;
                     end else if (mode_ff == MODE_ASK) begin
                        state_in = S_FETCH;
                     end else begin
                        bits_in  = '0;
                        gcnt_in  = '0;
                        state_in = S_GATHER;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_FETCH: begin
            ram_rd_en = 1'b1;
            state_in  = (mode_ff == MODE_ASK) ? S_ASK_BIT : S_PSK_BIT;
         end
         S_ASK_BIT: begin
            idle_in = cur_bit ? ~idle_ff : 1'b1;
            if ((tick_inc & (TICK_W + 1)'({TICK_W{1'b1}})) >= ask_limit) begin
               tc_in    = '0;
               bp_in    = adv_bp;
               head_in  = adv_head;
               count_in = adv_count;
            end else begin
               tc_in = tick_inc[TICK_W-1:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_GATHER: begin
            if (gcnt_ff == IW'(eff_n)) begin
               state_in = S_SYMBOL;
            end else if (count_ff != '0) begin
               state_in = S_FETCH;
            end else begin
               bits_in = SW'({bits_ff, 1'b0});
               gcnt_in = gcnt_ff + IW'(1);
            end
         end
         S_PSK_BIT: begin
            bits_in  = SW'({bits_ff, cur_bit});
            gcnt_in  = gcnt_ff + IW'(1);
            bp_in    = adv_bp;
            head_in  = adv_head;
            count_in = adv_count;
            state_in = S_GATHER;
         end
         S_SYMBOL: begin
            if (mode_ff == MODE_DPSK) begin
               sym_in = (sym_ff + bits_ff) & sym_mask;
            end else begin
               sym_in = bits_ff & sym_mask;
            end
            state_in = S_PHASE;
         end
         S_PHASE: begin
            idle_in = (phase < sym_half);
            if (tick_inc >= psk_limit) begin
               tc_in = '0;
            end else begin
               tc_in = tick_inc[TICK_W-1:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_ASK;
         bps_ff       <= BPS_W'(1);
         ppb_ff       <= PPB_W'(10);
         flen_ff      <= FLEN_W'(8);
         head_ff      <= '0;
         count_ff     <= '0;
         bp_ff        <= '0;
         tc_ff        <= '0;
         sym_ff       <= '0;
         idle_ff      <= 1'b1;
         finished_ff  <= 1'b1;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         bps_ff       <= bps_in;
         ppb_ff       <= ppb_in;
         flen_ff      <= flen_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         bp_ff        <= bp_in;
         tc_ff        <= tc_in;
         sym_ff       <= sym_in;
         idle_ff      <= idle_in;
         finished_ff  <= finished_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bits_ff <= bits_in;
      gcnt_ff <= gcnt_in;
   end

endmodule

// File: test/tb_ask_psk_bit_modulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ask_psk_bit_modulator_top
// Self-checking bench for the ASK / PSK / DPSK line modulator.
//
// Every request transfer is run through a cycle-free model of the queue and
// transmitter, and the predicted status is queued. Each rsp transfer is
// compared field by field against the oldest prediction. Directed cases come
// first, then a queue-full case under a long receiver hold-off, then random
// phases with a fresh register setting each.
// ----------------------------------------------------------------------------
module tb_ask_psk_bit_modulator_top;
   import apbm_pkg::*;

   localparam int QDEPTH        = QUEUE_DEPTH_DEF;
   localparam int FWIDTH        = FRAME_WIDTH_DEF;
   localparam int MAX_SYM_BITS  = MAX_SYMBOL_BITS_DEF;
   localparam int TARGET_ITEMS  = 1650;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [REQ_USER_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [MODE_W-1:0]     MODE_PSK   = 2'd1;
   localparam logic [MODE_W-1:0]     MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [6:0]           pad;
      logic [PENDING_W-1:0] pending;
      logic                 dropped;
      logic                 done;
      logic                 load;
   } line_status_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic [WORD_W-1:0]      req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   ask_psk_bit_modulator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transmitter model state
   logic [MODE_W-1:0] m_mode     = MODE_ASK;
   logic [BPS_W-1:0]  m_bps      = 3'd1;
   logic [PPB_W-1:0]  m_ppb      = 8'd10;
   logic [FLEN_W-1:0] m_flen     = 6'd8;
   logic [31:0]       m_queue [QDEPTH];
   int unsigned       m_head     = 0;
   int unsigned       m_count    = 0;
   int unsigned       m_bitpos   = 0;
   int unsigned       m_ticks    = 0;
   int unsigned       m_symbol   = 0;
   bit                m_idle     = 1'b1;
   bit                m_finished = 1'b1;

   line_status_type expected_status [$];
   int              mismatches    = 0;
   int              requests_sent = 0;
   int              burst_left    = 0;
   bit              hold_trigger  = 1'b0;
   bit              hold_active   = 1'b0;
   rx_pattern_type  rx_mode       = RX_OPEN;
   int unsigned     rx_cycle      = 0;

   function automatic int unsigned frame_bits();
      int unsigned len;
      len = m_flen;
      if (len < 1) len = 1;
      if (len > FWIDTH) len = FWIDTH;
      return len;
   endfunction

   function automatic int unsigned symbol_bits();
      int unsigned n;
      n = m_bps;
      if (n < 1) n = 1;
      if (n > MAX_SYM_BITS) n = MAX_SYM_BITS;
      return n;
   endfunction

   function automatic bit queue_bit();
      return m_queue[m_head % QDEPTH][m_bitpos];
   endfunction

   function automatic void step_bit();
      if (m_bitpos == 0) begin
         m_bitpos = frame_bits() - 1;
         m_head   = (m_head + 1) % QDEPTH;
         if (m_count > 0) m_count--;
      end else begin
         m_bitpos--;
      end
   endfunction

   function automatic line_status_type predict_line_status(logic [REQ_USER_W-1:0] kind,
                                                           logic [WORD_W-1:0] word);
      line_status_type s;
      int unsigned     n;
      int unsigned     period;
      int unsigned     span;
      int unsigned     bits;
      int              i;
      bit              dropped;
      dropped = 1'b0;
      case (kind)
         REQ_APPEND: begin
            if (m_count >= QDEPTH) begin
               dropped = 1'b1;
            end else begin
               m_queue[(m_head + m_count) % QDEPTH] = word;
               m_count++;
            end
         end
         REQ_START: begin
            m_bitpos   = frame_bits() - 1;
            m_ticks    = 0;
            m_symbol   = 0;
            m_idle     = 1'b1;
            m_finished = 1'b0;
         end
         REQ_TICK: begin
            if (!m_finished) begin
               if (m_mode == MODE_ASK) begin
                  if (m_count == 0) begin
                     m_idle     = 1'b0;
                     m_finished = 1'b1;
                  end else begin
                     if (queue_bit()) m_idle = !m_idle;
                     else m_idle = 1'b1;
                     m_ticks = (m_ticks + 1) & 12'hFFF;
                     if (m_ticks >= 2 * m_ppb) begin
                        m_ticks = 0;
                        step_bit();
                     end
                  end
               end else begin
                  n      = symbol_bits();
                  period = 1 << n;
                  span   = period * m_ppb;
                  if (m_ticks == 0 && m_count == 0) begin
                     m_idle     = 1'b0;
                     m_finished = 1'b1;
                  end else begin
                     if (m_ticks == 0) begin
                        bits = 0;
                        for (i = 0; i < n; i++) begin
                           bits = bits << 1;
                           if (m_count != 0) begin
                              bits = bits | queue_bit();
                              step_bit();
                           end
                        end
                        if (m_mode == MODE_DPSK) m_symbol = (m_symbol + bits) & (period - 1);
                        else m_symbol = bits & (period - 1);
                     end
                     m_idle = (((m_ticks + m_symbol) & (period - 1)) < (period >> 1));
                     m_ticks++;
                     if (m_ticks >= span) m_ticks = 0;
                     m_ticks = m_ticks & 12'hFFF;
                  end
               end
            end
         end
         default: ;
      endcase
      s.pad     = '0;
      s.pending = m_count[PENDING_W-1:0];
      s.dropped = dropped;
      s.done    = m_finished;
      s.load    = !m_idle;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 40)
         $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // result checker and request recorder
   always @(posedge clock) begin
      line_status_type want;
      line_status_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_status.size() == 0) begin
               report_mismatch("rsp transfer with nothing outstanding", rsp_tdata, -1);
            end else begin
               want = expected_status.pop_front();
               if (got.load !== want.load) report_mismatch("load_active", got.load, want.load);
               if (got.done !== want.done) report_mismatch("tx_done", got.done, want.done);
               if (got.dropped !== want.dropped)
                  report_mismatch("frame_dropped", got.dropped, want.dropped);
               if (got.pending !== want.pending)
                  report_mismatch("frames_pending", got.pending, want.pending);
               if (got.pad !== want.pad) report_mismatch("tdata padding", got.pad, want.pad);
            end
         end
         if (req_tvalid && req_tready)
            expected_status.push_back(predict_line_status(req_tuser, req_tdata));
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 256 == 0) rx_mode <= rx_pattern_type'($urandom_range(0, 3));
      if (reset || hold_active) begin
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
            default:   rsp_tready <= (rx_cycle % 3 == 0);
         endcase
      end
   end

   // long receiver hold-off
   always begin
      @(posedge clock);
      if (hold_trigger) begin
         hold_trigger <= 1'b0;
         hold_active  <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active  <= 1'b0;
      end
   end

   task automatic send_request(input logic [REQ_USER_W-1:0] kind, input logic [WORD_W-1:0] word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tuser  <= kind;
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (kind != REQ_UNUSED) requests_sent++;
   endtask

   task automatic send_noise();
      send_request(REQ_USER_W'($urandom_range(0, 3)), $urandom());
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_status.size() != 0) @(negedge clock);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_MODE: m_mode = value[MODE_W-1:0];
         REG_BPS:  m_bps  = value[BPS_W-1:0];
         REG_PPB:  m_ppb  = value[PPB_W-1:0];
         default:  m_flen = value[FLEN_W-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [MODE_W-1:0] mode, input logic [BPS_W-1:0] bps,
                            input logic [PPB_W-1:0] ppb, input logic [FLEN_W-1:0] flen);
      write_csr(REG_MODE, CSR_DATA_W'(mode));
      write_csr(REG_BPS, CSR_DATA_W'(bps));
      write_csr(REG_PPB, CSR_DATA_W'(ppb));
      write_csr(REG_FLEN, CSR_DATA_W'(flen));
      csr_we <= 1'b0;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(REQ_TICK, $urandom());
   endtask

   task automatic test_directed_cases();
      // defaults: tick while done, unused kind, start on empty queue
      send_request(REQ_TICK, 32'h0);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF);
      send_request(REQ_START, 32'h0);
      send_ticks(2);
      wait_idle();
      // ASK, zero periods, zero length acting as one bit
      configure(MODE_ASK, 3'd1, 8'd0, 6'd0);
      send_request(REQ_APPEND, 32'hFFFF_FFFF);
      send_request(REQ_APPEND, 32'h0000_0000);
      send_request(REQ_START, 32'hFFFF_FFFF);
      send_ticks(4);
      wait_idle();
      // spare mode as PSK, zero symbol width, oversized length
      configure(MODE_SPARE, 3'd0, 8'd0, 6'd63);
      send_request(REQ_APPEND, 32'h8000_0001);
      send_request(REQ_START, 32'h0);
      send_ticks(2);
      wait_idle();
      // DPSK, widest symbol, full frame
      configure(MODE_DPSK, 3'd4, 8'd0, 6'd32);
      send_request(REQ_APPEND, 32'hA5C3_0F96);
      send_request(REQ_START, 32'h0);
      send_ticks(10);
      wait_idle();
   endtask

   task automatic test_full_queue_stall();
      int frames;
      configure(MODE_ASK, 3'd1, 8'd0, 6'd1);
      hold_trigger <= 1'b1;
      repeat (QDEPTH + 2) send_request(REQ_APPEND, $urandom());
      wait_idle();
      frames = m_count;
      send_request(REQ_START, $urandom());
      send_ticks(frames + 2);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int          r;
      int unsigned frames;
      int unsigned n;
      int unsigned bit_total;
      int unsigned ticks;
      logic [MODE_W-1:0] mode;
      logic [BPS_W-1:0]  bps;
      logic [PPB_W-1:0]  ppb;
      logic [FLEN_W-1:0] flen;
      int appends;
      while (requests_sent < TARGET_ITEMS) begin
         r = $urandom_range(0, 9);
         mode = (r < 3) ? MODE_ASK : (r < 6) ? MODE_PSK : (r < 9) ? MODE_DPSK : MODE_SPARE;
         bps  = ($urandom_range(0, 9) == 0) ? BPS_W'($urandom_range(0, 7))
                                            : BPS_W'($urandom_range(1, 4));
         r = $urandom_range(0, 9);
         ppb  = (r < 6) ? PPB_W'($urandom_range(0, 3)) : (r < 8) ? PPB_W'($urandom_range(4, 20))
              : (r == 8) ? 8'd255 : PPB_W'($urandom_range(0, 255));
         r = $urandom_range(0, 9);
         flen = (r < 6) ? FLEN_W'($urandom_range(1, 8)) : (r == 6) ? 6'd32 : (r == 7) ? 6'd0
              : (r == 8) ? FLEN_W'($urandom_range(33, 63)) : FLEN_W'($urandom_range(9, 31));
         configure(mode, bps, ppb, flen);
         if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 4)) send_noise();
         appends = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
         frames = m_count + appends;
         if (frames > QDEPTH) frames = QDEPTH;
         repeat (appends) send_request(REQ_APPEND, $urandom());
         send_request(REQ_START, $urandom());
         bit_total = frames * frame_bits();
         if (m_mode == MODE_ASK) begin
            ticks = bit_total * ((m_ppb == 0) ? 1 : 2 * m_ppb);
         end else begin
            n = symbol_bits();
            ticks = ((bit_total + n - 1) / n) * ((m_ppb == 0) ? 1 : (1 << n) * m_ppb);
         end
         ticks += 2;
         if (ticks > 120) ticks = 120;
         repeat (ticks) begin
            r = $urandom_range(0, 99);
            if (r < 4) send_request(REQ_APPEND, $urandom());
            else if (r < 6) send_noise();
            else if (r == 6) send_request(REQ_START, $urandom());
            send_request(REQ_TICK, $urandom());
         end
         wait_idle();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_queue_stall();
      test_random_phases();
      wait_idle();
      if (expected_status.size() != 0)
         report_mismatch("results never delivered", 0, expected_status.size());
      if (mismatches == 0) begin
         $display("PASS ask_psk_bit_modulator_top");
      end else begin
         $display("FAIL ask_psk_bit_modulator_top");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL ask_psk_bit_modulator_top");
      $finish;
   end

endmodule
